// ===== rtl/bmnr_pkg.sv =====
// ----------------------------------------------------------------------------
// bmnr_pkg
// Shared types and constants of the binary mask nearest resampler.
// ----------------------------------------------------------------------------
`default_nettype none
package bmnr_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_NEXT  = 2'd2;

    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_DST_W = 2'd2;
    localparam logic [1:0] REG_DST_H = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] point_x;
        logic [15:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic       point_valid;
        logic       scan_done;
    } out_item_t;

    // Clamp a 9-bit size register into 1..maxv
    function automatic logic [12:0] clamp_size(input logic [8:0] v, input int maxv);
        logic [12:0] r;
        if (v == 9'd0) r = 13'd1;
        else if ({4'd0, v} > 13'(maxv)) r = 13'(maxv);
        else r = {4'd0, v};
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/binary_mask_nearest_resample_top.sv =====
// ----------------------------------------------------------------------------
// binary_mask_nearest_resample_top
// Binary mask loader and nearest-neighbor raster resampler.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready carrying req_type, point_x, point_y.
// A clear item wipes all 65536 bitmap entries one entry per cycle, during
// which in_ready is low. The same sweep runs after reset before the first
// item is taken. A set item inside the source area is written at its
// accepting edge; in_ready is high again the next cycle, with no result.
// A next item first rebuilds both coordinate units from the saved cursor,
// stepping the row unit up to the cursor row and then the column unit up to
// the cursor column. It then walks the raster: for each visited pixel it
// waits in ST_ROW for both units to settle, reads the bitmap in ST_READ and
// tests the bit in ST_TEST; at each row wrap it reloads the column unit and
// steps the row unit. It stops at the first set pixel or past the last row.
// One result per next item leaves on out_valid/out_ready from an output
// register; while it waits, in_ready stays low. Size registers (APB 0x0,
// 0x4, 0x8, 0xC) must be written only while idle; nothing here enforces it.
// ----------------------------------------------------------------------------
`default_nettype none
module binary_mask_nearest_resample_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bmnr_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bmnr_pkg::out_item_t      out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import bmnr_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SYNC_Y = 3'd2;
    localparam logic [2:0] ST_SYNC_X = 3'd3;
    localparam logic [2:0] ST_ROW    = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;
    localparam logic [2:0] ST_TEST   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [8:0] sw_reg, sh_reg, dw_reg, dh_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic [8:0] col_reg, col_next;
    logic [9:0] row_reg, row_next;
    logic [9:0] cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    out_item_t   oitem_reg, oitem_next;
    logic [12:0] sw, sh, dw, dh, xs, ys;
    logic        xload, xstep, yload, ystep;
    logic        xbusy, ybusy;
    logic        we, wbit, rbit;
    logic [AW-1:0] waddr, raddr;
    logic        wr_en;

    // APB registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 9'd256;
            sh_reg <= 9'd256;
            dw_reg <= 9'd256;
            dh_reg <= 9'd256;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SRC_W: sw_reg <= pwdata[8:0];
                REG_SRC_H: sh_reg <= pwdata[8:0];
                REG_DST_W: dw_reg <= pwdata[8:0];
                REG_DST_H: dh_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end
    always_comb
    begin
        unique case (paddr[3:2])
            REG_SRC_W: prdata = {23'd0, sw_reg};
            REG_SRC_H: prdata = {23'd0, sh_reg};
            REG_DST_W: prdata = {23'd0, dw_reg};
            default:   prdata = {23'd0, dh_reg};
        endcase
    end

    assign sw = clamp_size(sw_reg, MAX_WIDTH);
    assign sh = clamp_size(sh_reg, MAX_HEIGHT);
    assign dw = clamp_size(dw_reg, MAX_WIDTH);
    assign dh = clamp_size(dh_reg, MAX_HEIGHT);

    // Coordinate units: x reloaded each row, y stepped per row
    bmnr_mapper u_xmap (
        .clk(clk), .rst_n(rst_n), .load(xload), .step(xstep),
        .s_size(sw), .d_size(dw), .coord(xs), .busy(xbusy)
    );
    bmnr_mapper u_ymap (
        .clk(clk), .rst_n(rst_n), .load(yload), .step(ystep),
        .s_size(sh), .d_size(dh), .coord(ys), .busy(ybusy)
    );

    bmnr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bitmap (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wbit),
        .raddr(raddr), .rdata(rbit)
    );
    assign raddr = {ys[YW-1:0], xs[XW-1:0]};

    assign in_ready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        oitem_next  = oitem_reg;
        we    = 1'b0;
        wbit  = 1'b0;
        waddr = clr_reg;
        xload = 1'b0;
        xstep = 1'b0;
        yload = 1'b0;
        ystep = 1'b0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (in_item.req_type)
                        REQ_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            yload      = 1'b1;
                            xload      = 1'b1;
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        REQ_SET:
                        begin
                            if (in_item.point_x < 16'(sw) && in_item.point_y < 16'(sh))
                            begin
                                we    = 1'b1;
                                wbit  = 1'b1;
                                waddr = {in_item.point_y[YW-1:0], in_item.point_x[XW-1:0]};
                            end
                        end
                        REQ_NEXT:
                        begin
                            // sizes may have changed: rebuild both units from d = 0
                            xload      = 1'b1;
                            yload      = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_SYNC_Y;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SYNC_Y:
            begin
                // step the row unit up to the cursor row
                if (!ybusy)
                begin
                    if (cnt_reg == row_reg)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SYNC_X;
                    end
                    else
                    begin
                        ystep    = 1'b1;
                        cnt_next = cnt_reg + 10'd1;
                    end
                end
            end
            ST_SYNC_X:
            begin
                // step the column unit up to the cursor column
                if (!xbusy)
                begin
                    if (cnt_reg == {1'b0, col_reg})
                    begin
                        state_next = ST_ROW;
                    end
                    else
                    begin
                        xstep    = 1'b1;
                        cnt_next = cnt_reg + 10'd1;
                    end
                end
            end
            ST_ROW:
            begin
                // wait for both units to settle; finish past the last row, wrap cursor past width
                if (!xbusy && !ybusy)
                begin
                    if ({1'b0, row_reg} >= 11'(dh))
                    begin
                        ovalid_next = 1'b1;
                        oitem_next  = '{out_x: 8'd0, out_y: 8'd0,
                                        point_valid: 1'b0, scan_done: 1'b1};
                        state_next  = ST_IDLE;
                    end
                    else if (13'(col_reg) >= dw)
                    begin
                        col_next = '0;
                        row_next = row_reg + 10'd1;
                        xload    = 1'b1;
                        ystep    = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                col_next = col_reg + 9'd1;
                xstep    = 1'b1;
                if (rbit)
                begin
                    ovalid_next = 1'b1;
                    oitem_next  = '{out_x: col_reg[7:0], out_y: row_reg[7:0],
                                    point_valid: 1'b1, scan_done: 1'b0};
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ROW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oitem_reg <= oitem_next;
    end

    // Assertions
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> state_reg == ST_IDLE && !ovalid_reg)
        else $error("item accepted while busy");
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.point_valid != out_item.scan_done)
        else $error("result must carry exactly one flag");
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.scan_done |-> out_item.out_x == 8'd0 && out_item.out_y == 8'd0)
        else $error("done result with nonzero coordinates");
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready)
        else $error("ready during clearing sweep");
    a_read_settled: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !xbusy && !ybusy)
        else $error("bitmap read while a coordinate unit is busy");
endmodule
`default_nettype wire

// ===== rtl/bmnr_ram.sv =====
// ----------------------------------------------------------------------------
// bmnr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bmnr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/bmnr_mapper.sv =====
// ----------------------------------------------------------------------------
// bmnr_mapper
// Incremental nearest-coordinate tracker: keeps q = round(d*(s-1)/(n-1)) as d
// steps up by one, with one add/subtract unit used over several cycles.
// ----------------------------------------------------------------------------
`default_nettype none
module bmnr_mapper (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,     // restart at d = 0
    input  wire logic        step,     // advance d by one
    input  wire logic [12:0] s_size,
    input  wire logic [12:0] d_size,
    output logic [12:0]      coord,
    output logic             busy      // coord still catching up after a step
);
    // Invariant when idle: 2*d*(s-1) + (n-1) = coord*den + rem, 0 <= rem < den
    logic [13:0] den;
    logic [13:0] inc;
    logic [13:0] rem_reg, rem_next;
    logic [12:0] coord_reg, coord_next;
    logic        degen;

    assign degen = (s_size <= 13'd1) || (d_size <= 13'd1);
    assign den   = {d_size - 13'd1, 1'b0};
    assign inc   = {s_size - 13'd1, 1'b0};
    // One subtract per cycle until the remainder is back below den
    assign busy  = !degen && (rem_reg >= den);

    always_comb
    begin
        rem_next   = rem_reg;
        coord_next = coord_reg;
        if (load)
        begin
            rem_next   = {1'b0, d_size - 13'd1};
            coord_next = '0;
        end
        else if (busy)
        begin
            rem_next   = rem_reg - den;
            coord_next = coord_reg + 13'd1;
        end
        else if (step && !degen)
        begin
            rem_next = rem_reg + inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            coord_reg <= '0;
        end
        else
        begin
            rem_reg   <= rem_next;
            coord_reg <= coord_next;
        end
    end

    assign coord = degen ? 13'd0 : coord_reg;
endmodule
`default_nettype wire
